>>> src/crs_pkg.sv
package crs_pkg;

  localparam int COORD_BITS = 24;
  localparam int DATA_W     = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int STEP_W     = 17;
  localparam int T_W        = 17;
  localparam int LIM_W      = T_W + 1;
  localparam int T2_W       = 2 * T_W;
  localparam int T3_W       = 3 * T_W;
  localparam int B_W        = 56;
  localparam int W_SHIFT    = 21;
  localparam int W_W        = B_W - W_SHIFT;
  localparam int PROD_W     = W_W + COORD_BITS;
  localparam int ACC_W      = PROD_W + 2;
  localparam int O_SHIFT    = 28;
  localparam int R_W        = ACC_W - O_SHIFT;

  localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(1041);
  localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(65536);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(4096);
  localparam logic [LIM_W-1:0]  ONE_Q16    = LIM_W'(65536);

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_T_STEP = 1'b0;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t point_t [3];

  typedef struct packed {
    logic clear_t;
    logic issue;
    logic shift;
  } crs_cmd_t;

  typedef struct packed {
    logic last;
    logic busy;
    logic adv;
  } crs_stat_t;

endpackage

>>> src/catmull_rom_curve_sampler.sv
// Channel   Direction  tdata (low bit up)                  tuser / tlast
// in_       slave      point_x, point_y, point_z           tuser: start_curve
// out_      master     curve_x, curve_y, curve_z           tlast: last_sample
// cfg_      APB        t_step at byte address 0            -
//
// A point that closes a four-point window yields 2 to 64 samples, one per cycle
// through a six-stage pipeline; other points are only shifted into the window.
// The sample pipeline advances only when the output register is empty or taken,
// so a stalled output stalls every stage. Reset is synchronous and clears
// control state and the point window.
module catmull_rom_curve_sampler
  import crs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // point_x, point_y, point_z
  input  logic                  in_tuser,   // start_curve
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,  // curve_x, curve_y, curve_z
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [STEP_W-1:0] t_step_r;
  crs_cmd_t          cmd;
  crs_stat_t         stat;
  logic              reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1] == REG_T_STEP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_step_r <= STEP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      t_step_r <= cfg_pwdata[STEP_W-1:0];
    end
  end

  assign cfg_prdata = reg_sel ? 32'(t_step_r) : 32'd0;

  crs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  crs_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .t_step     (t_step_r),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> src/crs_ctrl.sv
module crs_ctrl
  import crs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_tuser,
  output logic      in_tready,
  input  crs_stat_t stat,
  output crs_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic       state_r, state_nxt;
  logic [1:0] seen_r, seen_nxt;
  logic [1:0] seen_eff;
  logic       accept;

  assign in_tready = (state_r == ST_IDLE) && !stat.busy;
  assign accept    = in_tvalid && in_tready;
  assign seen_eff  = in_tuser ? 2'd0 : seen_r;

  always_comb begin
    state_nxt   = state_r;
    seen_nxt    = seen_r;
    cmd.clear_t = 1'b0;
    cmd.issue   = 1'b0;
    cmd.shift   = accept;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          seen_nxt = (seen_eff == 2'd3) ? 2'd3 : seen_eff + 2'd1;
          if (seen_eff == 2'd3) begin
            cmd.clear_t = 1'b1;
            state_nxt   = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = stat.adv;
        if (stat.adv && stat.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

>>> src/crs_datapath.sv
module crs_datapath
  import crs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [STEP_W-1:0] t_step,
  input  logic [DATA_W-1:0] in_tdata,
  input  crs_cmd_t          cmd,
  output crs_stat_t         stat,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,
  output logic              out_tlast
);

  localparam logic signed [R_W-1:0] SAT_HI = R_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [R_W-1:0] SAT_LO = -SAT_HI - R_W'(1);

  logic [STEP_W-1:0] step;
  logic [LIM_W-1:0]  limit;
  logic [T_W-1:0]    t_r;
  logic              adv;

  // Four-point shift line: entries 0..2 are the earlier points, 3 the newest.
  point_t q_r [4];

  logic              v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic              l1_r, l2_r, l3_r, l4_r, l5_r, out_last_r;
  logic [T_W-1:0]    t1_r, t2a_r, t3a_r;
  logic [T2_W-1:0]   tt2_r, tt3b_r;
  logic [T3_W-1:0]   ttt3_r;
  logic signed [W_W-1:0]    w_r [4];
  logic signed [PROD_W-1:0] prod_r [3][4];
  coord_t            res_r [3];

  logic signed [B_W-1:0] te, t2e, t3e;
  logic signed [B_W-1:0] b [4];
  logic signed [B_W-1:0] b_rnd [4];
  logic signed [ACC_W-1:0] acc [3];
  logic signed [R_W-1:0]   rnd [3];
  coord_t                  sat [3];

  always_comb begin
    step = t_step;
    if (t_step < STEP_MIN) begin
      step = STEP_MIN;
    end else if (t_step > STEP_MAX) begin
      step = STEP_MAX;
    end
  end

  assign limit     = ONE_Q16 + LIM_W'(step);
  assign adv       = !out_valid_r || out_tready;
  assign stat.adv  = adv;
  assign stat.last = (LIM_W'(t_r) + LIM_W'(step)) >= limit;
  assign stat.busy = v1_r | v2_r | v3_r | v4_r | v5_r;

  always_ff @(posedge clk) begin
    if (cmd.clear_t) begin
      t_r <= '0;
    end else if (cmd.issue) begin
      t_r <= t_r + T_W'(step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        for (int c = 0; c < 3; c++) begin
          q_r[i][c] <= '0;
        end
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < 3; i++) begin
        q_r[i] <= q_r[i+1];
      end
      for (int c = 0; c < 3; c++) begin
        q_r[3][c] <= in_tdata[c*COORD_BITS +: COORD_BITS];
      end
    end
  end

  // Basis polynomials in Q48, each scaled by two, then rounded to the weights.
  always_comb begin
    te   = $signed(B_W'(t3a_r));
    t2e  = $signed(B_W'(tt3b_r));
    t3e  = $signed(B_W'(ttt3_r));
    b[0] = -(te <<< 32) + (t2e <<< 17) - t3e;
    b[1] = (B_W'(64'sd1) <<< 49) - (t2e <<< 18) - (t2e <<< 16) + (t3e <<< 1) + t3e;
    b[2] = (te <<< 32) + (t2e <<< 18) - (t3e <<< 1) - t3e;
    b[3] = -(t2e <<< 16) + t3e;
    for (int i = 0; i < 4; i++) begin
      b_rnd[i] = (b[i] + (B_W'(64'sd1) <<< (W_SHIFT - 1))) >>> W_SHIFT;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(prod_r[c][0]) + ACC_W'(prod_r[c][1])
             + ACC_W'(prod_r[c][2]) + ACC_W'(prod_r[c][3]);
      rnd[c] = R_W'((acc[c] + (ACC_W'(64'sd1) <<< (O_SHIFT - 1))) >>> O_SHIFT);
      if (rnd[c] > SAT_HI) begin
        sat[c] = SAT_HI[COORD_BITS-1:0];
      end else if (rnd[c] < SAT_LO) begin
        sat[c] = SAT_LO[COORD_BITS-1:0];
      end else begin
        sat[c] = rnd[c][COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r       <= t_r;
      l1_r       <= stat.last;
      tt2_r      <= T2_W'(t1_r) * T2_W'(t1_r);
      t2a_r      <= t1_r;
      l2_r       <= l1_r;
      ttt3_r     <= T3_W'(tt2_r) * T3_W'(t2a_r);
      tt3b_r     <= tt2_r;
      t3a_r      <= t2a_r;
      l3_r       <= l2_r;
      for (int i = 0; i < 4; i++) begin
        w_r[i] <= b_rnd[i][W_W-1:0];
      end
      l4_r       <= l3_r;
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < 4; i++) begin
          prod_r[c][i] <= w_r[i] * q_r[i][c];
        end
      end
      l5_r       <= l4_r;
      res_r      <= sat;
      out_last_r <= l5_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    out_tdata = '0;
    for (int c = 0; c < 3; c++) begin
      out_tdata[c*COORD_BITS +: COORD_BITS] = res_r[c];
    end
  end

endmodule
